[rtl/cft_pkg.sv]
// Shared types and constants of the CSV field tokenizer.
`default_nettype none

package cft_pkg;

  // Counter widths of the row and column indexes.
  localparam int unsigned ROW_BITS = 16;
  localparam int unsigned COL_BITS = 12;

  typedef logic [ROW_BITS-1:0] row_t;
  typedef logic [COL_BITS-1:0] col_t;

  // Byte codes that the parser reacts to.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] SEP_RESET = 8'h2C;

  // Operation codes of an input item.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // Kind codes of a result item.
  localparam logic [1:0] KIND_CONTENT = 2'd0;
  localparam logic [1:0] KIND_CELL    = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // Depth of the queue between front and back, and of the result queue.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One input item.
  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] content_byte;
    row_t       row;
    col_t       column;
    logic       stray_after_quote;
    logic       error_seen;
    row_t       first_error_row;
    logic       last;
  } result_t;

  // A classified item as the front hands it to the back.
  typedef struct packed {
    logic       eos;
    logic       is_cr;
    logic       is_lf;
    logic       is_quote;
    logic       is_sep;
    logic [7:0] data_byte;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/csv_field_tokenizer.sv]
// Top level of the streaming CSV field tokenizer.
//
//   channel   direction  handshake          payload
//   input     in         push / full        item_i   (operation, data_byte)
//   result    out        empty / pop        result_o (kind ... last)
//   config    in         cfg_we_i           cfg_wdata_i (separator)
//
// The parser takes one item per cycle while the result queue has room; an item
// with two results (a stray byte after a closing quote, or end of stream with
// an open cell) holds the parser for one step per result, set by the single
// result write port. The first result of an item passes the command queue and
// then the result queue register before it is on the result ports.
// Reset clears the queues, the parser state and sets the separator to comma.
// Either side may stall; the two-entry queues let the other side go on.
`default_nettype none

module csv_field_tokenizer (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [7:0]       cfg_wdata_i,
  input  wire logic             push,
  output logic                  full,
  input  wire cft_pkg::item_t   item_i,
  output logic                  empty,
  input  wire logic             pop,
  output cft_pkg::result_t      result_o
);

  logic             cmd_valid, cmd_pop;
  cft_pkg::cmd_t    cmd;
  logic             res_ready, res_we;
  cft_pkg::result_t res;

  // Front: classification and command queue.
  cft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // Back: parse state machine.
  cft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .res_ready_i (res_ready),
    .res_we_o    (res_we),
    .res_o       (res)
  );

  // Result queue.
  cft_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (res_we),
    .wdata_i  (res),
    .ready_o  (res_ready),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

[rtl/cft_front.sv]
// Front part: separator register, byte classification and the command queue.
`default_nettype none

module cft_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_wdata_i,
  input  wire logic          push,
  output logic               full,
  input  wire cft_pkg::item_t item_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_pop_i,
  output cft_pkg::cmd_t      cmd_o
);

  localparam int unsigned PtrBits = $clog2(cft_pkg::QUEUE_DEPTH);
  localparam int unsigned CntBits = $clog2(cft_pkg::QUEUE_DEPTH + 1);

  logic [7:0]         sep_q;
  cft_pkg::cmd_t      cmd_in;
  cft_pkg::cmd_t      mem_q [cft_pkg::QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               do_push, do_pop;

  // The user must write the separator register only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= cft_pkg::SEP_RESET;
    end else if (cfg_we_i) begin
      sep_q <= cfg_wdata_i;
    end
  end

  // Classify the incoming byte against the fixed codes and the separator.
  always_comb begin
    cmd_in.eos       = (item_i.operation == cft_pkg::OP_EOS);
    cmd_in.is_cr     = (item_i.data_byte == cft_pkg::CH_CR);
    cmd_in.is_lf     = (item_i.data_byte == cft_pkg::CH_LF);
    cmd_in.is_quote  = (item_i.data_byte == cft_pkg::CH_QUOTE);
    cmd_in.is_sep    = (item_i.data_byte == sep_q);
    cmd_in.data_byte = item_i.data_byte;
  end

  assign full        = (count_q == CntBits'(cft_pkg::QUEUE_DEPTH));
  assign do_push     = push && !full;
  assign cmd_valid_o = (count_q != '0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(cft_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(cft_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

[rtl/cft_back.sv]
// Back part: the parse state machine that turns commands into result items.
`default_nettype none

module cft_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output logic                cmd_pop_o,
  input  wire cft_pkg::cmd_t  cmd_i,
  input  wire logic           res_ready_i,
  output logic                res_we_o,
  output cft_pkg::result_t    res_o
);

  typedef enum logic [1:0] {
    MODE_START,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_QSEEN
  } mode_e;

  mode_e            mode_q, mode_d;
  logic             after_cr_q, after_cr_d;
  logic             line_has_q, line_has_d;
  cft_pkg::row_t    row_q, row_d;
  cft_pkg::col_t    col_q, col_d;
  logic             err_q, err_d;
  cft_pkg::row_t    err_row_q, err_row_d;
  cft_pkg::row_t    rows;
  logic             step;

  assign step = cmd_valid_i && res_ready_i;

  // One step of the parser per cycle while a command waits and the result queue
  // has room. An item with two results is stepped twice: the first step leaves the
  // mode at start of cell and keeps the command, so the second step produces the remaining result.
  always_comb begin
    mode_d     = mode_q;
    after_cr_d = after_cr_q;
    line_has_d = line_has_q;
    row_d      = row_q;
    col_d      = col_q;
    err_d      = err_q;
    err_row_d  = err_row_q;
    cmd_pop_o  = 1'b0;
    res_we_o   = 1'b0;
    rows       = row_q;

    res_o.kind              = cft_pkg::KIND_CELL;
    res_o.content_byte      = 8'h00;
    res_o.row               = row_q;
    res_o.column            = col_q;
    res_o.stray_after_quote = 1'b0;
    res_o.error_seen        = err_q;
    res_o.first_error_row   = err_row_q;
    res_o.last              = 1'b1;

    if (step) begin
      if (cmd_i.eos) begin
        if (mode_q != MODE_START) begin
          // Close the open cell first; the status follows next step.
          res_we_o   = 1'b1;
          res_o.last = 1'b0;
          mode_d     = MODE_START;
        end else begin
          // Report the status and clear the stream state.
          if (line_has_q && (row_q != '1)) begin
            rows = row_q + cft_pkg::row_t'(1);
          end
          res_we_o     = 1'b1;
          res_o.kind   = cft_pkg::KIND_STATUS;
          res_o.row    = rows;
          res_o.column = '0;
          cmd_pop_o    = 1'b1;
          after_cr_d   = 1'b0;
          line_has_d   = 1'b0;
          row_d        = '0;
          col_d        = '0;
          err_d        = 1'b0;
          err_row_d    = '0;
        end
      end else if (cmd_i.is_cr || cmd_i.is_lf) begin
        // Line end; an LF right after a CR is swallowed.
        cmd_pop_o  = 1'b1;
        after_cr_d = cmd_i.is_cr;
        if (!(cmd_i.is_lf && after_cr_q)) begin
          res_we_o   = (mode_q != MODE_START);
          if (row_q != '1) begin
            row_d = row_q + cft_pkg::row_t'(1);
          end
          col_d      = '0;
          line_has_d = 1'b0;
          mode_d     = MODE_START;
        end
      end else begin
        cmd_pop_o  = 1'b1;
        after_cr_d = 1'b0;
        line_has_d = 1'b1;
        unique case (mode_q)
          MODE_START: begin
            if (cmd_i.is_quote) begin
              mode_d = MODE_QUOTED;
            end else if (cmd_i.is_sep) begin
              res_we_o = 1'b1;
              if (col_q != '1) begin
                col_d = col_q + cft_pkg::col_t'(1);
              end
            end else begin
              res_we_o           = 1'b1;
              res_o.kind         = cft_pkg::KIND_CONTENT;
              res_o.content_byte = cmd_i.data_byte;
              mode_d             = MODE_PLAIN;
            end
          end
          MODE_PLAIN: begin
            res_we_o = 1'b1;
            if (cmd_i.is_sep) begin
              if (col_q != '1) begin
                col_d = col_q + cft_pkg::col_t'(1);
              end
              mode_d = MODE_START;
            end else begin
              res_o.kind         = cft_pkg::KIND_CONTENT;
              res_o.content_byte = cmd_i.data_byte;
            end
          end
          MODE_QUOTED: begin
            if (cmd_i.is_quote) begin
              mode_d = MODE_QSEEN;
            end else begin
              res_we_o           = 1'b1;
              res_o.kind         = cft_pkg::KIND_CONTENT;
              res_o.content_byte = cmd_i.data_byte;
            end
          end
          MODE_QSEEN: begin
            res_we_o = 1'b1;
            if (cmd_i.is_quote) begin
              // A doubled quote stands for one quote.
              res_o.kind         = cft_pkg::KIND_CONTENT;
              res_o.content_byte = cmd_i.data_byte;
              mode_d             = MODE_QUOTED;
            end else if (cmd_i.is_sep) begin
              if (col_q != '1) begin
                col_d = col_q + cft_pkg::col_t'(1);
              end
              mode_d = MODE_START;
            end else begin
              // Stray byte after the closing quote: close the cell with the
              // stray flag and keep the command, so the byte then opens a
              // plain cell in the same column.
              cmd_pop_o               = 1'b0;
              err_d                   = 1'b1;
              err_row_d               = err_q ? err_row_q : row_q;
              res_o.stray_after_quote = 1'b1;
              res_o.error_seen        = 1'b1;
              res_o.first_error_row   = err_q ? err_row_q : row_q;
              res_o.last              = 1'b0;
              mode_d                  = MODE_START;
            end
          end
          default: begin
            mode_d = MODE_START;
          end
        endcase
      end
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_START;
      after_cr_q <= 1'b0;
      line_has_q <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      err_q      <= 1'b0;
      err_row_q  <= '0;
    end else begin
      mode_q     <= mode_d;
      after_cr_q <= after_cr_d;
      line_has_q <= line_has_d;
      row_q      <= row_d;
      col_q      <= col_d;
      err_q      <= err_d;
      err_row_q  <= err_row_d;
    end
  end

endmodule

`default_nettype wire

[rtl/cft_outq.sv]
// Result queue that parts the parser from the consumer.
`default_nettype none

module cft_outq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire cft_pkg::result_t wdata_i,
  output logic                  ready_o,
  output logic                  empty,
  input  wire logic             pop,
  output cft_pkg::result_t      result_o
);

  localparam int unsigned PtrBits = $clog2(cft_pkg::QUEUE_DEPTH);
  localparam int unsigned CntBits = $clog2(cft_pkg::QUEUE_DEPTH + 1);

  cft_pkg::result_t   mem_q [cft_pkg::QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] count_q;
  logic               do_push, do_pop;

  assign ready_o  = (count_q != CntBits'(cft_pkg::QUEUE_DEPTH));
  assign empty    = (count_q == '0);
  assign do_push  = we_i && ready_o;
  assign do_pop   = pop && !empty;
  assign result_o = mem_q[rd_ptr_q];

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(cft_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(cft_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[tb/sv/csv_field_tokenizer_test.sv]
// Self-checking testbench of the CSV field tokenizer: directed table and random CSV text.
`timescale 1ns / 100ps

module csv_field_tokenizer_test;

  // Parse modes of the local tokenizer model.
  typedef enum logic [1:0] {MODE_START, MODE_PLAIN, MODE_QUOTED, MODE_QSEEN} parse_mode_e;

  // One input item with its expected tokens, typed in where they are obvious.
  typedef struct packed {
    cft_pkg::item_t   item;
    logic             fixed;
    logic [1:0]       n_fixed;
    cft_pkg::result_t tok0;
    cft_pkg::result_t tok1;
  } text_row_t;

  localparam logic [7:0] SEP_CHOICES [7] = '{8'h00, 8'hFF, 8'h09, 8'h3B, cft_pkg::CH_QUOTE,
                                             cft_pkg::CH_CR, cft_pkg::SEP_RESET};

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    cfg_we_i    = 1'b0;
  logic    [7:0] cfg_wdata_i = '0;
  logic    push        = 1'b0;
  logic    full;
  cft_pkg::item_t   item_i = '0;
  logic    empty;
  logic    pop         = 1'b0;
  cft_pkg::result_t result_o;

  // Tokenizer model state.
  parse_mode_e   mode        = MODE_START;
  logic          cr_pending  = 1'b0;
  logic          line_open   = 1'b0;
  cft_pkg::row_t row_cnt     = '0;
  cft_pkg::col_t col_cnt     = '0;
  logic          err_flag    = 1'b0;
  cft_pkg::row_t err_row     = '0;
  logic [7:0]    separator_reg = cft_pkg::SEP_RESET;
  cft_pkg::result_t step_res [2];
  int            step_n;

  // Ring buffers of expected tokens and of items waiting to be accepted.
  cft_pkg::result_t exp_fifo [64];
  logic [5:0]    exp_wr = '0;
  logic [5:0]    exp_rd = '0;
  int            exp_count = 0;
  text_row_t     row_fifo [64];
  logic [5:0]    row_wr = '0;
  logic [5:0]    row_rd = '0;
  text_row_t     directed_rows [32];
  int            n_directed = 0;

  logic [7:0]  active_sep = cft_pkg::SEP_RESET;
  int          idle_pct = 0;
  int          mismatches = 0;
  int          tokens_checked = 0;
  int          stray_tokens = 0;
  int          eos_items = 0;
  int          items_sent = 0;
  int          sep_writes = 0;

  csv_field_tokenizer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic cft_pkg::result_t token(logic [1:0] kind, logic [7:0] b,
                                             cft_pkg::row_t r, cft_pkg::col_t c,
                                             logic stray, logic err, cft_pkg::row_t ferr,
                                             logic last);
    cft_pkg::result_t t;
    t.kind = kind;
    t.content_byte = b;
    t.row = r;
    t.column = c;
    t.stray_after_quote = stray;
    t.error_seen = err;
    t.first_error_row = ferr;
    t.last = last;
    return t;
  endfunction

  function automatic text_row_t text_row(logic op, logic [7:0] b, logic fixed, logic [1:0] n,
                                         cft_pkg::result_t t0, cft_pkg::result_t t1);
    text_row_t r;
    r.item.operation = op;
    r.item.data_byte = b;
    r.fixed = fixed;
    r.n_fixed = n;
    r.tok0 = t0;
    r.tok1 = t1;
    return r;
  endfunction

  // Add one row to the directed table.
  function automatic void add_row(text_row_t r);
    directed_rows[n_directed] = r;
    n_directed++;
  endfunction

  // Queue one expected token.
  function automatic void expect_token(cft_pkg::result_t t);
    exp_fifo[exp_wr] = t;
    exp_wr++;
    exp_count++;
  endfunction

  // Append one token, tagged with the current error status.
  function automatic void emit(logic [1:0] kind, logic [7:0] b, cft_pkg::row_t r,
                               cft_pkg::col_t c, logic stray);
    step_res[step_n] = token(kind, b, r, c, stray, err_flag, err_row, 1'b0);
    step_n++;
  endfunction

  function automatic void close_cell_and_advance();
    emit(cft_pkg::KIND_CELL, 8'h00, row_cnt, col_cnt, 1'b0);
    if (col_cnt != '1) col_cnt++;
    mode = MODE_START;
  endfunction

  // Work out the tokens that one input item causes and update the model state.
  function automatic void tokenize(cft_pkg::item_t it);
    cft_pkg::row_t rows;
    logic [7:0]    b;
    logic          swallow;
    b = it.data_byte;
    step_n = 0;
    if (it.operation == cft_pkg::OP_EOS) begin
      rows = row_cnt;
      if (mode != MODE_START) emit(cft_pkg::KIND_CELL, 8'h00, row_cnt, col_cnt, 1'b0);
      if (line_open && rows != '1) rows++;
      emit(cft_pkg::KIND_STATUS, 8'h00, rows, '0, 1'b0);
      mode = MODE_START;
      cr_pending = 1'b0;
      line_open = 1'b0;
      row_cnt = '0;
      col_cnt = '0;
      err_flag = 1'b0;
      err_row = '0;
    end else if (b == cft_pkg::CH_CR || b == cft_pkg::CH_LF) begin
      // A line end closes any open cell; LF right after CR is part of the same line end.
      swallow = (b == cft_pkg::CH_LF) && cr_pending;
      cr_pending = (b == cft_pkg::CH_CR);
      if (!swallow) begin
        if (mode != MODE_START) emit(cft_pkg::KIND_CELL, 8'h00, row_cnt, col_cnt, 1'b0);
        if (row_cnt != '1) row_cnt++;
        col_cnt = '0;
        line_open = 1'b0;
        mode = MODE_START;
      end
    end else begin
      cr_pending = 1'b0;
      line_open = 1'b1;
      case (mode)
        MODE_START: begin
          if (b == cft_pkg::CH_QUOTE) mode = MODE_QUOTED;
          else if (b == separator_reg) close_cell_and_advance();
          else begin
            emit(cft_pkg::KIND_CONTENT, b, row_cnt, col_cnt, 1'b0);
            mode = MODE_PLAIN;
          end
        end
        MODE_PLAIN: begin
          if (b == separator_reg) close_cell_and_advance();
          else emit(cft_pkg::KIND_CONTENT, b, row_cnt, col_cnt, 1'b0);
        end
        MODE_QUOTED: begin
          if (b == cft_pkg::CH_QUOTE) mode = MODE_QSEEN;
          else emit(cft_pkg::KIND_CONTENT, b, row_cnt, col_cnt, 1'b0);
        end
        default: begin
          if (b == cft_pkg::CH_QUOTE) begin
            emit(cft_pkg::KIND_CONTENT, b, row_cnt, col_cnt, 1'b0);
            mode = MODE_QUOTED;
          end else if (b == separator_reg) begin
            close_cell_and_advance();
          end else begin
            // Stray byte after the closing quote: flag it, then start a plain cell here.
            if (!err_flag) begin
              err_flag = 1'b1;
              err_row = row_cnt;
            end
            emit(cft_pkg::KIND_CELL, 8'h00, row_cnt, col_cnt, 1'b1);
            emit(cft_pkg::KIND_CONTENT, b, row_cnt, col_cnt, 1'b0);
            mode = MODE_PLAIN;
          end
        end
      endcase
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at token %0d: %s", tokens_checked, msg);
  endtask

  // Sample both handshakes at the rising edge: predict accepted items, check accepted tokens.
  always @(posedge clk_i) begin
    text_row_t        r;
    cft_pkg::result_t exp_tok;
    if (rst_ni) begin
      if (cfg_we_i) separator_reg = cfg_wdata_i;
      if (push && !full) begin
        r = row_fifo[row_rd];
        row_rd++;
        tokenize(item_i);
        if (r.fixed) begin
          if (r.n_fixed > 0) expect_token(r.tok0);
          if (r.n_fixed > 1) expect_token(r.tok1);
        end else begin
          for (int k = 0; k < step_n; k++) expect_token(step_res[k]);
        end
        if (item_i.operation == cft_pkg::OP_EOS) eos_items++;
      end
      if (pop && !empty) begin
        if (exp_count == 0) begin
          report_mismatch($sformatf("unexpected token %p", result_o));
        end else begin
          exp_tok = exp_fifo[exp_rd];
          exp_rd++;
          exp_count--;
          if (result_o.kind !== exp_tok.kind)
            report_mismatch($sformatf("kind exp %0d got %0d", exp_tok.kind, result_o.kind));
          if (result_o.content_byte !== exp_tok.content_byte)
            report_mismatch($sformatf("content_byte exp %02h got %02h",
                                      exp_tok.content_byte, result_o.content_byte));
          if (result_o.row !== exp_tok.row)
            report_mismatch($sformatf("row exp %0d got %0d", exp_tok.row, result_o.row));
          if (result_o.column !== exp_tok.column)
            report_mismatch($sformatf("column exp %0d got %0d", exp_tok.column, result_o.column));
          if (result_o.stray_after_quote !== exp_tok.stray_after_quote)
            report_mismatch($sformatf("stray_after_quote exp %0b got %0b",
                                      exp_tok.stray_after_quote, result_o.stray_after_quote));
          if (result_o.error_seen !== exp_tok.error_seen)
            report_mismatch($sformatf("error_seen exp %0b got %0b",
                                      exp_tok.error_seen, result_o.error_seen));
          if (result_o.first_error_row !== exp_tok.first_error_row)
            report_mismatch($sformatf("first_error_row exp %0d got %0d",
                                      exp_tok.first_error_row, result_o.first_error_row));
          if (result_o.last !== exp_tok.last)
            report_mismatch($sformatf("last exp %0b got %0b", exp_tok.last, result_o.last));
        end
        if (result_o.stray_after_quote === 1'b1) stray_tokens++;
        tokens_checked++;
      end
    end
  end

  // Token side: pop with random stall bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 17) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Drive one item, with an occasional gap before it, and wait until it is taken.
  task automatic send_item(text_row_t r);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    row_fifo[row_wr] = r;
    row_wr++;
    push <= 1'b1;
    item_i <= r.item;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(text_row(cft_pkg::OP_DATA, b, 1'b0, 2'd0, '0, '0));
  endtask

  // The data byte of an end-of-stream item is random since the block ignores it.
  task automatic send_eos();
    send_item(text_row(cft_pkg::OP_EOS, 8'($urandom_range(0, 255)), 1'b0, 2'd0, '0, '0));
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == cft_pkg::CH_QUOTE || b == cft_pkg::CH_CR || b == cft_pkg::CH_LF ||
           b == active_sep);
    return b;
  endfunction

  function automatic logic [7:0] quoted_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == cft_pkg::CH_QUOTE || b == cft_pkg::CH_CR || b == cft_pkg::CH_LF);
    return b;
  endfunction

  // One well-formed line of cells with random content, sometimes with a stray byte.
  task automatic send_record();
    int unsigned n_cells;
    int unsigned len;
    n_cells = $urandom_range(1, 6);
    for (int c = 0; c < n_cells; c++) begin
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          len = $urandom_range(1, 5);
          repeat (len) send_byte(plain_byte());
        end
        default: begin
          send_byte(cft_pkg::CH_QUOTE);
          len = $urandom_range(0, 5);
          repeat (len) begin
            case ($urandom_range(0, 5))
              0: begin
                send_byte(cft_pkg::CH_QUOTE);
                send_byte(cft_pkg::CH_QUOTE);
              end
              1: send_byte(active_sep);
              default: send_byte(quoted_byte());
            endcase
          end
          send_byte(cft_pkg::CH_QUOTE);
          if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) send_byte(plain_byte());
        end
      endcase
      if (c < n_cells - 1 || $urandom_range(0, 5) == 0) send_byte(active_sep);
    end
    case ($urandom_range(0, 3))
      0: send_byte(cft_pkg::CH_LF);
      1: send_byte(cft_pkg::CH_CR);
      default: begin
        send_byte(cft_pkg::CH_CR);
        send_byte(cft_pkg::CH_LF);
      end
    endcase
    if ($urandom_range(0, 7) == 0) send_byte(cft_pkg::CH_LF);
    if ($urandom_range(0, 9) == 0) send_eos();
  endtask

  // A short burst of arbitrary bytes, weighted toward the ones the parser reacts to.
  task automatic send_noise();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0: send_byte(cft_pkg::CH_QUOTE);
        1: send_byte(cft_pkg::CH_CR);
        2: send_byte(cft_pkg::CH_LF);
        3: send_byte(active_sep);
        4: begin
          if ($urandom_range(0, 3) == 0) send_eos();
          else send_byte(8'($urandom_range(0, 255)));
        end
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Wait until every expected token is out and the pipeline has drained.
  task automatic settle();
    push <= 1'b0;
    while (exp_count != 0) @(posedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_separator(logic [7:0] sep);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= sep;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    active_sep = sep;
    sep_writes++;
  endtask

  initial begin
    int phase_start;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed text with the reset separator (comma).
    add_row(text_row(cft_pkg::OP_EOS, 8'h00, 1'b1, 2'd1,
            token(cft_pkg::KIND_STATUS, 8'h00, 0, 0, 0, 0, 0, 1), '0));
    add_row(text_row(cft_pkg::OP_DATA, 8'h61, 1'b1, 2'd1,
            token(cft_pkg::KIND_CONTENT, 8'h61, 0, 0, 0, 0, 0, 1), '0));
    add_row(text_row(cft_pkg::OP_DATA, 8'h2C, 1'b1, 2'd1,
            token(cft_pkg::KIND_CELL, 8'h00, 0, 0, 0, 0, 0, 1), '0));
    // Separator at start of cell gives an empty cell.
    add_row(text_row(cft_pkg::OP_DATA, 8'h2C, 1'b1, 2'd1,
            token(cft_pkg::KIND_CELL, 8'h00, 0, 1, 0, 0, 0, 1), '0));
    // Opening quote gives nothing.
    add_row(text_row(cft_pkg::OP_DATA, cft_pkg::CH_QUOTE, 1'b1, 2'd0, '0, '0));
    add_row(text_row(cft_pkg::OP_DATA, 8'h2C, 1'b0, 2'd0, '0, '0));
    add_row(text_row(cft_pkg::OP_DATA, cft_pkg::CH_QUOTE, 1'b0, 2'd0, '0, '0));
    add_row(text_row(cft_pkg::OP_DATA, cft_pkg::CH_QUOTE, 1'b0, 2'd0, '0, '0));
    add_row(text_row(cft_pkg::OP_DATA, cft_pkg::CH_QUOTE, 1'b0, 2'd0, '0, '0));
    // Stray byte after the closing quote.
    add_row(text_row(cft_pkg::OP_DATA, 8'h78, 1'b1, 2'd2,
            token(cft_pkg::KIND_CELL, 8'h00, 0, 2, 1, 1, 0, 0),
            token(cft_pkg::KIND_CONTENT, 8'h78, 0, 2, 0, 1, 0, 1)));
    add_row(text_row(cft_pkg::OP_DATA, 8'h2C, 1'b0, 2'd0, '0, '0));
    // Trailing separator, then CR LF and an empty line, which give no tokens.
    add_row(text_row(cft_pkg::OP_DATA, cft_pkg::CH_CR, 1'b1, 2'd0, '0, '0));
    add_row(text_row(cft_pkg::OP_DATA, cft_pkg::CH_LF, 1'b1, 2'd0, '0, '0));
    add_row(text_row(cft_pkg::OP_DATA, cft_pkg::CH_LF, 1'b1, 2'd0, '0, '0));
    add_row(text_row(cft_pkg::OP_DATA, 8'hFF, 1'b1, 2'd1,
            token(cft_pkg::KIND_CONTENT, 8'hFF, 2, 0, 0, 1, 0, 1), '0));
    add_row(text_row(cft_pkg::OP_DATA, 8'h00, 1'b1, 2'd1,
            token(cft_pkg::KIND_CONTENT, 8'h00, 2, 0, 0, 1, 0, 1), '0));
    add_row(text_row(cft_pkg::OP_DATA, cft_pkg::CH_CR, 1'b0, 2'd0, '0, '0));
    // A line end inside a quoted cell closes it.
    add_row(text_row(cft_pkg::OP_DATA, cft_pkg::CH_QUOTE, 1'b0, 2'd0, '0, '0));
    add_row(text_row(cft_pkg::OP_DATA, 8'h71, 1'b0, 2'd0, '0, '0));
    add_row(text_row(cft_pkg::OP_DATA, cft_pkg::CH_LF, 1'b0, 2'd0, '0, '0));
    add_row(text_row(cft_pkg::OP_DATA, cft_pkg::CH_QUOTE, 1'b0, 2'd0, '0, '0));
    // End of stream with an open cell on an unfinished line.
    add_row(text_row(cft_pkg::OP_EOS, 8'h5A, 1'b1, 2'd2,
            token(cft_pkg::KIND_CELL, 8'h00, 4, 0, 0, 1, 0, 0),
            token(cft_pkg::KIND_STATUS, 8'h00, 5, 0, 0, 1, 0, 1)));
    add_row(text_row(cft_pkg::OP_EOS, 8'hFF, 1'b1, 2'd1,
            token(cft_pkg::KIND_STATUS, 8'h00, 0, 0, 0, 0, 0, 1), '0));
    for (int i = 0; i < n_directed; i++) send_item(directed_rows[i]);

    // Random CSV text under each separator, the extremes among them.
    foreach (SEP_CHOICES[s]) begin
      settle();
      set_separator(SEP_CHOICES[s]);
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 4;
        default: idle_pct = 20;
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < 130) begin
        if ($urandom_range(0, 4) != 0) send_record();
        else send_noise();
      end
    end

    // A last stretch at full rate: empty cells, a line, then an error on the next line.
    settle();
    set_separator(cft_pkg::SEP_RESET);
    idle_pct = 0;
    send_eos();
    repeat (3) send_byte(cft_pkg::SEP_RESET);
    send_byte(8'h41);
    send_byte(cft_pkg::CH_LF);
    send_byte(cft_pkg::CH_QUOTE);
    send_byte(8'h62);
    send_byte(cft_pkg::CH_QUOTE);
    send_byte(8'h7A);
    send_byte(cft_pkg::SEP_RESET);
    send_byte(8'h63);
    send_eos();

    push <= 1'b0;
    for (int i = 0; i < 4000 && exp_count != 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (exp_count != 0)
      report_mismatch($sformatf("%0d expected tokens never arrived", exp_count));

    $display("Sent %0d items (%0d end-of-stream) under %0d separator settings.",
             items_sent, eos_items, sep_writes + 1);
    $display("Checked %0d tokens, %0d of them closed by a stray byte; %0d mismatches.",
             tokens_checked, stray_tokens, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #(20_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
rtl/cft_pkg.sv
rtl/cft_front.sv
rtl/cft_back.sv
rtl/cft_outq.sv
rtl/csv_field_tokenizer.sv
tb/sv/csv_field_tokenizer_test.sv
